@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the evaluator RTL.
// Concurrent checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define IEE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// cons must hold in the cycle after ante
`define IEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define IEE_ASSERT(lbl, clk, rst_n, prop)
`define IEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/iee_pkg.sv @@
// Shared types and constants of the infix expression evaluator.
// No dependencies; every RTL module imports this package.
package iee_pkg;

    localparam int WORD_W    = 32;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int DIV_CNT_W = $clog2(WORD_W);

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_BADCHAR = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_expr;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status_code;
    } t_out_word;

    typedef enum logic [2:0] {
        K_DIGIT, K_SPACE, K_MUL, K_DIV, K_ADD, K_SUB, K_CLOSE, K_BAD
    } t_kind;

    // classified character as queued between front and back
    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       close;
    } t_tok;

    typedef enum logic [1:0] {
        OP_NONE, OP_MUL, OP_DIV
    } t_mul_op;

    typedef enum logic [1:0] {
        S_FETCH, S_FN, S_DIV, S_POST
    } t_back_state;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              div_zero;
        logic [WORD_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ hw/rtl/infix_expression_evaluator_core.sv @@
// Top level of the streaming infix expression evaluator.
// Depends on iee_pkg, iee_front, iee_div and iee_back.
//
// Characters come in one word at a time on the push/full side; a finished
// expression leaves as one word on the empty/pop side, holding the 32-bit
// wrapped value and a status (ok, divide by zero, bad character; the first
// error seen wins). Numbers combine with + - * /, where * and / bind tighter,
// both levels left to right; spaces are skipped, an empty operand is zero,
// and '=', newline or the end flag closes the expression and clears state.
// The front classifies each character and drops it into a four-entry token
// queue, so it takes a word every cycle until that queue fills. The back
// sequencer drains the queue: a digit, space or bad character needs only its
// fetch, + - * / go through fetch, fold pending number and apply operator,
// and a close adds a fold and the output step. Folding a pending division
// runs the iterative divider, one quotient bit a cycle; a zero divisor skips
// the bit steps. That divider sets the worst case: the slowest character is
// one that finishes a quotient, slower still when that character is a '/'
// carrying the end flag, since the close then folds a second, zero-divisor
// division. A result waiting in the output register does not stop the back
// until the next close needs that register.

module infix_expression_evaluator_core import iee_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_in_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_out_word
);

    t_tok     w_tok;
    logic     w_tok_valid, w_tok_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic     w_out_valid;

    // classify and queue
    iee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .o_tok       (w_tok),
        .o_tok_valid (w_tok_valid),
        .i_tok_pop   (w_tok_pop)
    );

    // divider for pending '/', driven by the back
    iee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // evaluate tokens, hold the finished result word
    iee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_tok),
        .i_tok_valid (w_tok_valid),
        .o_tok_pop   (w_tok_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_word  (o_out_word),
        .o_out_valid (w_out_valid),
        .i_out_pop   (pop)
    );

    assign empty = !w_out_valid;

endmodule

@@ hw/rtl/iee_front.sv @@
// Front end: classifies incoming characters and queues the tokens.
// Depends on iee_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iee_front import iee_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_word i_in_word,
    output t_tok     o_tok,
    output logic     o_tok_valid,
    input  logic     i_tok_pop
);

    t_tok              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    t_tok              w_tok;
    logic              w_push, w_pop;

    always_comb begin
        w_tok.digit = 4'd0;
        w_tok.close = i_in_word.end_of_expr;
        case (i_in_word.char_code) inside
            [CH_ZERO:CH_NINE]: begin
                w_tok.kind  = K_DIGIT;
                w_tok.digit = 4'(i_in_word.char_code - CH_ZERO);
            end
            CH_SPACE: w_tok.kind = K_SPACE;
            CH_STAR:  w_tok.kind = K_MUL;
            CH_SLASH: w_tok.kind = K_DIV;
            CH_PLUS:  w_tok.kind = K_ADD;
            CH_MINUS: w_tok.kind = K_SUB;
            CH_EQ, CH_LF: begin
                w_tok.kind  = K_CLOSE;
                w_tok.close = 1'b1;
            end
            default:  w_tok.kind = K_BAD;
        endcase
    end

    assign full        = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_tok_valid = (r_cnt != '0);
    assign o_tok       = r_q[r_rd];
    assign w_push      = push && !full;
    assign w_pop       = i_tok_pop && o_tok_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `IEE_ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, w_push && !w_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

@@ hw/rtl/iee_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on iee_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iee_div import iee_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy, r_done, r_zero, r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [WORD_W-1:0]    r_rem, r_quo, r_den;
    logic [WORD_W-1:0]    w_ua, w_ub;
    logic [WORD_W:0]      w_shift, w_diff;
    logic                 w_ge;

    assign w_ua    = i_req.dividend[WORD_W-1] ? (WORD_W)'(0) - i_req.dividend
                                              : i_req.dividend;
    assign w_ub    = i_req.divisor[WORD_W-1]  ? (WORD_W)'(0) - i_req.divisor
                                              : i_req.divisor;
    // restoring step: bring down next dividend bit, try subtract
    assign w_shift = {r_rem, r_quo[WORD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = !w_diff[WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_zero <= 1'b0;
            r_neg  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_neg  <= i_req.dividend[WORD_W-1] ^ i_req.divisor[WORD_W-1];
                r_zero <= (w_ub == '0);
                r_cnt  <= '0;
                if (w_ub == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == (DIV_CNT_W)'(WORD_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= (w_ub == '0) ? '0 : w_ua;
            r_den <= w_ub;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WORD_W-1:0] : w_shift[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_zero;
    assign o_rsp.quotient = r_neg ? (WORD_W)'(0) - r_quo : r_quo;

    `IEE_ASSERT(a_no_restart, i_clk, i_rst_n, !(i_req.start && r_busy))
    `IEE_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy)

endmodule

@@ hw/rtl/iee_back.sv @@
// Back end: sequencer that folds tokens into number, term and sum.
// Depends on iee_pkg and assert_macros.svh; drives the divider.
`include "assert_macros.svh"

module iee_back import iee_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tok      i_tok,
    input  logic      i_tok_valid,
    output logic      o_tok_pop,
    output t_div_req  o_div_req,
    input  t_div_rsp  i_div_rsp,
    output t_out_word o_out_word,
    output logic      o_out_valid,
    input  logic      i_out_pop
);

    t_back_state       r_state, n_state;
    logic              r_phase, n_phase;  // 1: closing pass
    t_kind             r_kind, n_kind;
    logic              r_close, n_close;
    logic [WORD_W-1:0] r_num, n_num;
    logic [WORD_W-1:0] r_term, n_term;
    logic [WORD_W-1:0] r_sum, n_sum;
    t_mul_op           r_pend, n_pend;
    logic              r_neg, n_neg;
    logic [1:0]        r_err, n_err;
    t_out_word         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [WORD_W-1:0] w_prod, w_sum, w_num10;

    assign w_prod  = r_term * r_num;
    assign w_sum   = r_neg ? r_sum - r_term : r_sum + r_term;
    // times ten as two shifts
    assign w_num10 = (r_num << 3) + (r_num << 1) + (WORD_W)'(i_tok.digit);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_close     = r_close;
        n_num       = r_num;
        n_term      = r_term;
        n_sum       = r_sum;
        n_pend      = r_pend;
        n_neg       = r_neg;
        n_err       = r_err;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_pop;
        o_tok_pop   = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_term;
        o_div_req.divisor  = r_num;

        case (r_state)
            S_FETCH: begin
                if (i_tok_valid) begin
                    o_tok_pop = 1'b1;
                    n_kind    = i_tok.kind;
                    n_close   = i_tok.close;
                    n_phase   = 1'b1;
                    case (i_tok.kind)
                        K_DIGIT: begin
                            n_num = w_num10;
                            if (i_tok.close) begin
                                n_state = S_FN;
                            end
                        end
                        K_SPACE: begin
                            if (i_tok.close) begin
                                n_state = S_FN;
                            end
                        end
                        K_BAD: begin
                            if (r_err == ST_OK) begin
                                n_err = ST_BADCHAR;
                            end
                            if (i_tok.close) begin
                                n_state = S_FN;
                            end
                        end
                        K_CLOSE: begin
                            n_state = S_FN;
                        end
                        default: begin
                            // operator: fold number first, then apply it
                            n_phase = 1'b0;
                            n_state = S_FN;
                        end
                    endcase
                end
            end
            S_FN: begin
                case (r_pend)
                    OP_MUL:  n_term = w_prod;
                    OP_DIV:  o_div_req.start = 1'b1;
                    default: n_term = r_num;
                endcase
                n_num   = '0;
                n_pend  = OP_NONE;
                n_state = (r_pend == OP_DIV) ? S_DIV : S_POST;
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_term = i_div_rsp.quotient;
                    if (i_div_rsp.div_zero && r_err == ST_OK) begin
                        n_err = ST_DIVZERO;
                    end
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!r_phase) begin
                    case (r_kind)
                        K_MUL: n_pend = OP_MUL;
                        K_DIV: n_pend = OP_DIV;
                        K_ADD, K_SUB: begin
                            n_sum  = w_sum;
                            n_term = '0;
                            n_neg  = (r_kind == K_SUB);
                        end
                        default: n_pend = r_pend;
                    endcase
                    n_phase = 1'b1;
                    n_state = r_close ? S_FN : S_FETCH;
                end else if (!r_out_valid || i_out_pop) begin
                    n_out.result_value = w_sum;
                    n_out.status_code  = r_err;
                    n_out_valid        = 1'b1;
                    n_num   = '0;
                    n_term  = '0;
                    n_sum   = '0;
                    n_pend  = OP_NONE;
                    n_neg   = 1'b0;
                    n_err   = ST_OK;
                    n_state = S_FETCH;
                end
            end
            default: n_state = S_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_phase     <= 1'b0;
            r_kind      <= K_SPACE;
            r_close     <= 1'b0;
            r_num       <= '0;
            r_term      <= '0;
            r_sum       <= '0;
            r_pend      <= OP_NONE;
            r_neg       <= 1'b0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_close     <= n_close;
            r_num       <= n_num;
            r_term      <= n_term;
            r_sum       <= n_sum;
            r_pend      <= n_pend;
            r_neg       <= n_neg;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;

    `IEE_ASSERT(a_pop_fetch, i_clk, i_rst_n, !o_tok_pop || (r_state == S_FETCH && i_tok_valid))
    `IEE_ASSERT_NEXT(a_div_wait, i_clk, i_rst_n, o_div_req.start, r_state == S_DIV)
    `IEE_ASSERT(a_div_clear, i_clk, i_rst_n, r_state != S_DIV || r_pend == OP_NONE)

endmodule

@@ test/tb_top.sv @@
// Testbench for infix_expression_evaluator_core: streams character words in,
// predicts each finished expression in a scoreboard and checks every result word.
// Depends on iee_pkg and the evaluator RTL only.

import iee_pkg::*;

// Tracks the evaluator state word by word and queues the totals it expects.
class expr_scoreboard;
    logic [31:0] number_acc;
    logic [31:0] term_acc;
    logic [31:0] sum_acc;
    t_mul_op     mul_op;
    logic        sub_term;
    logic [1:0]  status;
    t_out_word   expected_totals[$];
    int unsigned fail_count;

    function new();
        fail_count = 0;
        clear();
    endfunction

    function void clear();
        number_acc = '0;
        term_acc   = '0;
        sum_acc    = '0;
        mul_op     = OP_NONE;
        sub_term   = 1'b0;
        status     = ST_OK;
    endfunction

    // first error sticks until the close
    function void flag(input logic [1:0] code);
        if (status == ST_OK) begin
            status = code;
        end
    endfunction

    // fold the number being typed into the current term (empty number is 0)
    function void fold_number();
        logic [31:0] num_mag;
        logic [31:0] den_mag;
        logic [31:0] quo;
        if (mul_op == OP_MUL) begin
            term_acc = term_acc * number_acc;
        end else if (mul_op == OP_DIV) begin
            num_mag = term_acc[31] ? 32'd0 - term_acc : term_acc;
            den_mag = number_acc[31] ? 32'd0 - number_acc : number_acc;
            if (den_mag == 32'd0) begin
                flag(ST_DIVZERO);
                term_acc = '0;
            end else begin
                // truncate toward zero; min / -1 wraps back to min
                quo = num_mag / den_mag;
                term_acc = (term_acc[31] != number_acc[31]) ? 32'd0 - quo : quo;
            end
        end else begin
            term_acc = number_acc;
        end
        number_acc = '0;
        mul_op     = OP_NONE;
    endfunction

    function void fold_term();
        sum_acc  = sub_term ? sum_acc - term_acc : sum_acc + term_acc;
        term_acc = '0;
        sub_term = 1'b0;
    endfunction

    function void note_input(input t_in_word w);
        logic      close_now;
        t_out_word total;
        close_now = w.end_of_expr;
        case (w.char_code)
            CH_SPACE: ;
            CH_STAR, CH_SLASH: begin
                fold_number();
                if (w.char_code == CH_STAR) begin
                    mul_op = OP_MUL;
                end else begin
                    mul_op = OP_DIV;
                end
            end
            CH_PLUS, CH_MINUS: begin
                fold_number();
                fold_term();
                sub_term = (w.char_code == CH_MINUS);
            end
            CH_EQ, CH_LF: close_now = 1'b1;
            default: begin
                if (w.char_code >= CH_ZERO && w.char_code <= CH_NINE) begin
                    number_acc = number_acc * 32'd10 + 32'(w.char_code - CH_ZERO);
                end else begin
                    flag(ST_BADCHAR);
                end
            end
        endcase
        if (close_now) begin
            fold_number();
            fold_term();
            total.result_value = sum_acc;
            total.status_code  = status;
            expected_totals.push_back(total);
            clear();
        end
    endfunction

    function void check_result(input t_out_word got);
        t_out_word want;
        if (expected_totals.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("unexpected result word: value %0d status %0d",
                         got.result_value, got.status_code);
            end
            return;
        end
        want = expected_totals.pop_front();
        if (got.result_value !== want.result_value || got.status_code !== want.status_code) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                         want.result_value, want.status_code,
                         got.result_value, got.status_code);
            end
        end
    endfunction

    function int unsigned waiting();
        return expected_totals.size();
    endfunction
endclass

module tb_top;
    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           push = 1'b0;
    logic           full;
    t_in_word       i_in_word = '0;
    logic           empty;
    logic           pop = 1'b0;
    t_out_word      o_out_word;
    logic           steady_phase = 1'b0;
    int unsigned    sent_words = 0;
    expr_scoreboard sb;

    infix_expression_evaluator_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: pop stalls about a fifth of the time except in the steady stretch
    always @(negedge i_clk) begin
        pop <= steady_phase || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_out_word);
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_in_word make_word(input logic [7:0] ch, input logic eoe);
        t_in_word w;
        w.char_code   = ch;
        w.end_of_expr = eoe;
        return w;
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Called and returns at a falling edge; push stays high across back-to-back words.
    task automatic send_word(input t_in_word w);
        while (!steady_phase && $urandom_range(0, 99) < 21) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (full);
        sb.note_input(w);
        sent_words++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input logic close_on_last);
        for (int k = 0; k < s.len(); k++) begin
            send_word(make_word(s[k], close_on_last && (k == s.len() - 1)));
        end
    endtask

    // Well-formed expression with random numbers, operators and spacing,
    // occasionally a stray byte, closed by '=', newline or the end flag.
    task automatic send_expression();
        t_in_word words[$];
        t_in_word last;
        string    digits;
        int       n_operands;
        int       n_digits;
        int       kind;
        n_operands = $urandom_range(1, 6);
        if ($urandom_range(0, 9) == 0) begin
            words.push_back(make_word(pick_op(), 1'b0));
        end
        for (int k = 0; k < n_operands; k++) begin
            if (k > 0) begin
                if ($urandom_range(0, 6) == 0) words.push_back(make_word(CH_SPACE, 1'b0));
                words.push_back(make_word(pick_op(), 1'b0));
                if ($urandom_range(0, 6) == 0) words.push_back(make_word(CH_SPACE, 1'b0));
            end
            // one operand in seven is left empty
            if ($urandom_range(0, 6) != 0) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    words.push_back(make_word(CH_ZERO, 1'b0));
                end else if (kind == 1) begin
                    case ($urandom_range(0, 3))
                        0:       digits = "2147483647";
                        1:       digits = "2147483648";
                        2:       digits = "4294967295";
                        default: digits = "98765432109876";
                    endcase
                    for (int j = 0; j < digits.len(); j++) begin
                        words.push_back(make_word(digits[j], 1'b0));
                    end
                end else begin
                    n_digits = (kind < 4) ? $urandom_range(4, 12) : $urandom_range(1, 3);
                    for (int j = 0; j < n_digits; j++) begin
                        words.push_back(make_word(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0));
                    end
                end
            end
            if ($urandom_range(0, 32) == 0) begin
                words.push_back(make_word(8'($urandom_range(0, 255)), 1'b0));
            end
        end
        case ($urandom_range(0, 3))
            0: words.push_back(make_word(CH_EQ, 1'b0));
            1: words.push_back(make_word(CH_LF, 1'b0));
            2: words.push_back(make_word(($urandom_range(0, 1) != 0) ? CH_EQ : CH_LF, 1'b1));
            default: begin
                if (words.size() == 0) begin
                    words.push_back(make_word(CH_SPACE, 1'b1));
                end else begin
                    last = words.pop_back();
                    last.end_of_expr = 1'b1;
                    words.push_back(last);
                end
            end
        endcase
        foreach (words[j]) begin
            send_word(words[j]);
        end
    endtask

    // raw bytes with a rare end flag
    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            send_word(make_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0));
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // most negative value over -1, closed by the end flag on the last digit
        send_text("2147483648/4294967295", 1'b1);
        // empty operands, NUL and 0xFF as bad characters, later divide by zero,
        // newline carrying the end flag
        send_text("+5*", 1'b0);
        send_word(make_word(8'h00, 1'b0));
        send_word(make_word(CH_SLASH, 1'b0));
        send_word(make_word(8'hFF, 1'b0));
        send_text(" -", 1'b0);
        send_word(make_word(CH_LF, 1'b1));
        // divide by zero alone
        send_text("9/0=", 1'b0);

        while (sent_words < 1585) begin
            steady_phase = (sent_words >= 600 && sent_words < 900);
            if ($urandom_range(0, 9) == 0) begin
                send_noise();
            end else begin
                send_expression();
            end
        end
        steady_phase = 1'b0;
        push <= 1'b0;

        while (sb.waiting() != 0) @(posedge i_clk);
        // room for a stray word after the last expected one
        repeat (100) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
